>>> rtl/pye_pkg.sv
package pye_pkg;

  // Largest palette the block is built for, and the queue between front and back
  localparam int unsigned PALETTE_DEPTH_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH           = 2;

  // Register indexes on the configuration channel
  localparam logic CFG_OUTPUT_FORMAT = 1'b0;
  localparam logic CFG_ENTRY_COUNT   = 1'b1;

  // Output byte orders
  localparam logic [2:0] FMT_YUVA = 3'd0;
  localparam logic [2:0] FMT_ARGB = 3'd1;
  localparam logic [2:0] FMT_RGBA = 3'd2;
  localparam logic [2:0] FMT_BGRA = 3'd3;
  localparam logic [2:0] FMT_ABGR = 3'd4;

  // BT.601 studio-range gains, 10 fractional bits
  localparam int unsigned SUM_W  = 22;
  localparam int unsigned FRAC   = 10;
  localparam logic signed [12:0] GAIN_Y  = 13'sd1192;
  localparam logic signed [12:0] GAIN_RV = 13'sd1634;
  localparam logic signed [12:0] GAIN_GU = 13'sd401;
  localparam logic signed [12:0] GAIN_GV = 13'sd832;
  localparam logic signed [12:0] GAIN_BU = 13'sd2066;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(512);
  localparam logic signed [9:0] Y_OFFSET = 10'sd16;

  // Kind of request after classification
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PIXEL,
    OP_SKIP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] index;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] a;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Drop negatives to zero, take the integer part, saturate at 255
  function automatic logic [7:0] clamp_shift(logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:FRAC+8]) begin
      res = 8'hFF;
    end else begin
      res = sum[FRAC+7:FRAC];
    end
    return res;
  endfunction

endpackage

>>> rtl/pye_queue.sv
module pye_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pye_pkg::item_t  push_item,
  input  logic            pop,
  output pye_pkg::item_t  head,
  output pye_pkg::q_stat_t stat
);

  localparam int unsigned PW = (pye_pkg::QUEUE_DEPTH > 1) ? $clog2(pye_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(pye_pkg::QUEUE_DEPTH + 1);

  pye_pkg::item_t entries [pye_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (count == CW'(pye_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Hold requests in order
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(pye_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(pye_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/pye_front.sv
module pye_front #(
  parameter int unsigned PALETTE_DEPTH = pye_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic             start,
  input  logic             action,
  input  logic [7:0]       palette_index,
  input  logic [7:0]       entry_y,
  input  logic [7:0]       entry_u,
  input  logic [7:0]       entry_v,
  input  logic [7:0]       entry_a,
  input  logic [8:0]       entry_count,
  input  pye_pkg::q_stat_t q_stat,
  output logic             busy,
  output logic             push,
  output pye_pkg::item_t   push_item
);

  logic out_of_range;
  logic out_of_depth;

  // Stall the caller only while the queue is full; drop writes past the store
  assign busy = q_stat.full;
  assign push = start && !q_stat.full && !(!action && out_of_depth);

  // Skip pixels past the loaded entries or past the store
  assign out_of_depth = ({1'b0, palette_index} >= 9'(PALETTE_DEPTH));
  assign out_of_range = ({1'b0, palette_index} >= entry_count) || out_of_depth;

  always_comb begin
    push_item.index = palette_index;
    push_item.y     = entry_y;
    push_item.u     = entry_u;
    push_item.v     = entry_v;
    push_item.a     = entry_a;
    if (!action) begin
      push_item.op = pye_pkg::OP_WRITE;
    end else begin
      push_item.op = out_of_range ? pye_pkg::OP_SKIP : pye_pkg::OP_PIXEL;
    end
  end

endmodule

>>> rtl/pye_back.sv
module pye_back #(
  parameter int unsigned PALETTE_DEPTH = pye_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  pye_pkg::item_t   head,
  input  pye_pkg::q_stat_t q_stat,
  input  logic [2:0]       output_format,
  output logic             pop,
  output logic             result_valid,
  output logic [7:0]       byte0,
  output logic [7:0]       byte1,
  output logic [7:0]       byte2,
  output logic [7:0]       byte3,
  output logic             keep_previous
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned SW = pye_pkg::SUM_W;

  logic [31:0]    palette [PALETTE_DEPTH];
  logic [AW-1:0]  addr;

  // Stage one: memory access
  logic           s1_valid;
  pye_pkg::op_t   s1_op;
  logic [31:0]    rd_data;

  // Stage two: products
  logic           s2_valid;
  logic           s2_skip;
  logic [31:0]    s2_entry;
  logic signed [SW-1:0] prod_y;
  logic signed [SW-1:0] prod_rv;
  logic signed [SW-1:0] prod_gu;
  logic signed [SW-1:0] prod_gv;
  logic signed [SW-1:0] prod_bu;

  logic signed [9:0]    y_off;
  logic signed [7:0]    cb;
  logic signed [7:0]    cr;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_g;
  logic signed [SW-1:0] sum_b;
  logic [7:0]           r;
  logic [7:0]           g;
  logic [7:0]           b;
  logic [7:0]           ey;
  logic [7:0]           eu;
  logic [7:0]           ev;
  logic [7:0]           ea;
  logic [7:0]           o0_next;
  logic [7:0]           o1_next;
  logic [7:0]           o2_next;
  logic [7:0]           o3_next;

  // Drain one request every cycle
  assign pop  = !q_stat.empty;
  assign addr = head.index[AW-1:0];

  // Write entries in request order, read the looked-up one
  always_ff @(posedge clk) begin
    if (pop && head.op == pye_pkg::OP_WRITE) begin
      palette[addr] <= {head.y, head.u, head.v, head.a};
    end
    if (pop) begin
      rd_data <= palette[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pop && head.op != pye_pkg::OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op <= head.op;
    end
  end

  // Remove the offsets from the stored entry
  assign y_off = $signed({2'b00, rd_data[31:24]}) - pye_pkg::Y_OFFSET;
  assign cb    = $signed({~rd_data[23], rd_data[22:16]});
  assign cr    = $signed({~rd_data[15], rd_data[14:8]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_skip  <= (s1_op == pye_pkg::OP_SKIP);
    s2_entry <= rd_data;
    prod_y   <= SW'(y_off) * SW'(pye_pkg::GAIN_Y);
    prod_rv  <= SW'(cr) * SW'(pye_pkg::GAIN_RV);
    prod_gu  <= SW'(cb) * SW'(pye_pkg::GAIN_GU);
    prod_gv  <= SW'(cr) * SW'(pye_pkg::GAIN_GV);
    prod_bu  <= SW'(cb) * SW'(pye_pkg::GAIN_BU);
  end

  // Sum, round and clamp each colour
  assign sum_r = prod_y + prod_rv + pye_pkg::HALF;
  assign sum_g = prod_y - prod_gu - prod_gv + pye_pkg::HALF;
  assign sum_b = prod_y + prod_bu + pye_pkg::HALF;
  assign r     = pye_pkg::clamp_shift(sum_r);
  assign g     = pye_pkg::clamp_shift(sum_g);
  assign b     = pye_pkg::clamp_shift(sum_b);
  assign ey    = s2_entry[31:24];
  assign eu    = s2_entry[23:16];
  assign ev    = s2_entry[15:8];
  assign ea    = s2_entry[7:0];

  // Pack in the selected byte order; a skipped pixel gives all zeros
  always_comb begin
    o0_next = ey;
    o1_next = eu;
    o2_next = ev;
    o3_next = ea;
    if (s2_skip) begin
      o0_next = 8'd0;
      o1_next = 8'd0;
      o2_next = 8'd0;
      o3_next = 8'd0;
    end else begin
      case (output_format)
        pye_pkg::FMT_ARGB: begin
          o0_next = ea; o1_next = r; o2_next = g; o3_next = b;
        end
        pye_pkg::FMT_RGBA: begin
          o0_next = r; o1_next = g; o2_next = b; o3_next = ea;
        end
        pye_pkg::FMT_BGRA: begin
          o0_next = b; o1_next = g; o2_next = r; o3_next = ea;
        end
        pye_pkg::FMT_ABGR: begin
          o0_next = ea; o1_next = b; o2_next = g; o3_next = r;
        end
        default: begin
          o0_next = ey; o1_next = eu; o2_next = ev; o3_next = ea;
        end
      endcase
      // A transparent entry gives all zeros in the RGB orders
      if (ea == 8'd0 && output_format inside {pye_pkg::FMT_ARGB, pye_pkg::FMT_RGBA,
                                               pye_pkg::FMT_BGRA, pye_pkg::FMT_ABGR}) begin
        o0_next = 8'd0;
        o1_next = 8'd0;
        o2_next = 8'd0;
        o3_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    byte0         <= o0_next;
    byte1         <= o1_next;
    byte2         <= o2_next;
    byte3         <= o3_next;
    keep_previous <= s2_skip;
  end

endmodule

>>> rtl/palette_yuva_to_rgba_expander.sv
// Palette expander: indexed pixels to YUVA or packed RGB with alpha.
// Request channel: a request is taken at a rising edge with start high and
// busy low. action 0 loads palette entry palette_index with entry_y/u/v/a;
// action 1 looks palette_index up and yields one result.
// Result channel: byte0..byte3 and keep_previous are valid for exactly one
// cycle while result_valid is high; the receiver has no way to stall, so
// every result must be taken in that cycle. Loads yield no result.
// Configuration: cfg_valid/cfg_ready carry cfg_index and cfg_data; index 0
// is output_format, index 1 is entry_count. cfg_ready is always high, and
// registers are to be written only while no request is in flight.
// Timing: a lookup passes the queue, the palette read register, the
// product register and the output registers before result_valid
// goes high. A short queue feeds a back end that drains one request per
// cycle through the single-port palette memory, so one request per cycle
// is sustained and busy stays low in normal use.
// Reset clears the control state, output_format and entry_count; palette
// entries are undefined until loaded.
module palette_yuva_to_rgba_expander #(
  parameter int unsigned PALETTE_DEPTH = pye_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       action,
  input  logic [7:0] palette_index,
  input  logic [7:0] entry_y,
  input  logic [7:0] entry_u,
  input  logic [7:0] entry_v,
  input  logic [7:0] entry_a,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  output logic       result_valid,
  output logic [7:0] byte0,
  output logic [7:0] byte1,
  output logic [7:0] byte2,
  output logic [7:0] byte3,
  output logic       keep_previous
);

  logic [2:0]       output_format;
  logic [8:0]       entry_count;
  logic             push;
  logic             pop;
  pye_pkg::item_t   push_item;
  pye_pkg::item_t   head;
  pye_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_format <= pye_pkg::FMT_YUVA;
      entry_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pye_pkg::CFG_OUTPUT_FORMAT: output_format <= cfg_data[2:0];
        pye_pkg::CFG_ENTRY_COUNT:   entry_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  pye_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .start         (start),
    .action        (action),
    .palette_index (palette_index),
    .entry_y       (entry_y),
    .entry_u       (entry_u),
    .entry_v       (entry_v),
    .entry_a       (entry_a),
    .entry_count   (entry_count),
    .q_stat        (q_stat),
    .busy          (busy),
    .push          (push),
    .push_item     (push_item)
  );

  pye_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  pye_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .output_format (output_format),
    .pop           (pop),
    .result_valid  (result_valid),
    .byte0         (byte0),
    .byte1         (byte1),
    .byte2         (byte2),
    .byte3         (byte3),
    .keep_previous (keep_previous)
  );

  // Back end drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("request channel stalled");

  // A lookup yields a result, a load yields none
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 (result_valid == $past(action, 4)))
    else $error("result timing wrong");

  // Skipped pixels carry zero bytes
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && keep_previous) |->
      (byte0 == 8'd0 && byte1 == 8'd0 && byte2 == 8'd0 && byte3 == 8'd0))
    else $error("skipped pixel with non-zero bytes");

endmodule
